>>> src/sbu8x_pkg.sv
// ----------------------------------------------------------------------------
// sbu8x_pkg: shared types and tables of the single-byte to utf-8 recoder
// item structs, the job handed from front to back, code tables
// ----------------------------------------------------------------------------
package sbu8x_pkg;

  localparam int PREFIX_LEN = 5;
  localparam int DECL_LEN   = 38;
  localparam int IDX_W      = $clog2(DECL_LEN);
  localparam int JOBQ_DEPTH = 2;

  localparam logic [8*PREFIX_LEN-1:0] PREFIX_STR = "<?xml";
  localparam logic [8*DECL_LEN-1:0]   DECL_STR   =
    "<?xml version=\"1.0\" encoding=\"UTF-8\"?>";

  localparam logic [7:0] CHR_QUEST = 8'h3f;
  localparam logic [7:0] CHR_GT    = 8'h3e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_doc;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // work for one accepted item: prefix flush, then code point or declaration
  typedef struct packed {
    logic [2:0]  flush_cnt;
    logic        do_code;
    logic [1:0]  code_len;
    logic [15:0] cp;
    logic        do_decl;
  } job_t;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_DECL   = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    SEG_START = 4'b0001,
    SEG_FLUSH = 4'b0010,
    SEG_CODE  = 4'b0100,
    SEG_DECL  = 4'b1000
  } seg_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < PREFIX_LEN) begin
      c = PREFIX_STR[(PREFIX_LEN - 1 - int'(idx)) * 8 +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] decl_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < DECL_LEN) begin
      c = DECL_STR[(DECL_LEN - 1 - int'(idx)) * 8 +: 8];
    end
    return c;
  endfunction

  // windows-1252 code points of bytes 0x80..0x9f
  function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
    logic [15:0] cp;
    unique case (idx)
      5'd0:  cp = 16'h20ac;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201a;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201e;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02c6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h008d;
      5'd14: cp = 16'h017d;
      5'd15: cp = 16'h008f;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201c;
      5'd20: cp = 16'h201d;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02dc;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203a;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h009d;
      5'd30: cp = 16'h017e;
      5'd31: cp = 16'h0178;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

endpackage

>>> src/sbu8x_front.sv
// ----------------------------------------------------------------------------
// sbu8x_front: input classifier
// tracks the xml prefix and declaration, maps the byte to a code point
// and hands one job per item that has output
// ----------------------------------------------------------------------------
module sbu8x_front import sbu8x_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output job_t     job
);

  logic       enc_r;
  phase_t     phase_r, phase_nxt;
  logic [2:0] matched_r, matched_nxt;
  logic       saw_q_r, saw_q_nxt;
  logic [15:0] cp;
  logic        is_high;

  // code point and its utf-8 length
  always_comb begin
    is_high = (item.in_byte[7:5] == 3'b100);
    if (enc_r && is_high) begin
      cp = cp1252_map(item.in_byte[4:0]);
    end else begin
      cp = {8'h00, item.in_byte};
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    matched_nxt = matched_r;
    saw_q_nxt   = saw_q_r;
    job         = '0;
    job.cp      = cp;
    if (cp < 16'h0080) begin
      job.code_len = 2'd1;
    end else if (cp < 16'h0800) begin
      job.code_len = 2'd2;
    end else begin
      job.code_len = 2'd3;
    end

    unique case (phase_r)
      PH_PREFIX: begin
        if ((int'(matched_r) < PREFIX_LEN) &&
            (item.in_byte == prefix_char(matched_r))) begin
          matched_nxt = matched_r + 3'd1;
          if (int'(matched_nxt) >= PREFIX_LEN) begin
            phase_nxt = PH_DECL;
            saw_q_nxt = 1'b0;
          end
        end else begin
          // broken prefix: flush what matched, then the byte itself
          job.flush_cnt = matched_r;
          job.do_code   = 1'b1;
          phase_nxt     = PH_BODY;
        end
      end
      PH_DECL: begin
        if (saw_q_r && (item.in_byte == CHR_GT)) begin
          job.do_decl = 1'b1;
          phase_nxt   = PH_BODY;
          saw_q_nxt   = 1'b0;
        end else begin
          saw_q_nxt = (item.in_byte == CHR_QUEST);
        end
      end
      default: begin
        job.do_code = 1'b1;
      end
    endcase

    if (item.end_of_doc) begin
      // partial prefix at end of document goes out unchanged
      if (phase_nxt == PH_PREFIX) begin
        job.flush_cnt = matched_nxt;
      end
      phase_nxt   = PH_PREFIX;
      matched_nxt = 3'd0;
      saw_q_nxt   = 1'b0;
    end
  end

  assign job_push = accept && ((job.flush_cnt != 3'd0) || job.do_code || job.do_decl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r     <= 1'b0;
      phase_r   <= PH_PREFIX;
      matched_r <= 3'd0;
      saw_q_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        enc_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        matched_r <= matched_nxt;
        saw_q_r   <= saw_q_nxt;
      end
    end
  end

  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PREFIX) |-> (int'(matched_r) < PREFIX_LEN))
    else $error("prefix match count out of range");

  a_no_match_outside_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> !saw_q_r)
    else $error("question mark flag set in body");

endmodule

>>> src/sbu8x_jobq.sv
// ----------------------------------------------------------------------------
// sbu8x_jobq: short job queue between front and back
// ----------------------------------------------------------------------------
module sbu8x_jobq import sbu8x_pkg::*; #(
  parameter int DEPTH = JOBQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job queue underflow");

endmodule

>>> src/sbu8x_back.sv
// ----------------------------------------------------------------------------
// sbu8x_back: output sequencer
// walks the head job one byte per cycle into a free or popped output register
// ----------------------------------------------------------------------------
module sbu8x_back import sbu8x_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  seg_t             seg_r, seg_cur, seg_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             adv;
  logic             job_last;
  logic [7:0]       byte_cur;

  assign adv = !q_empty && (!out_valid_r || out_pop);

  always_comb begin
    if (seg_r == SEG_START) begin
      if (head.flush_cnt != 3'd0) begin
        seg_cur = SEG_FLUSH;
      end else if (head.do_decl) begin
        seg_cur = SEG_DECL;
      end else begin
        seg_cur = SEG_CODE;
      end
    end else begin
      seg_cur = seg_r;
    end
  end

  always_comb begin
    byte_cur = 8'h00;
    job_last = 1'b0;
    seg_nxt  = seg_cur;
    idx_nxt  = idx_r + IDX_W'(1);
    unique case (seg_cur)
      SEG_FLUSH: begin
        byte_cur = prefix_char(idx_r[2:0]);
        if (idx_r[2:0] == head.flush_cnt - 3'd1) begin
          if (head.do_code) begin
            seg_nxt = SEG_CODE;
            idx_nxt = '0;
          end else begin
            job_last = 1'b1;
          end
        end
      end
      SEG_CODE: begin
        unique case (head.code_len)
          2'd1: byte_cur = head.cp[7:0];
          2'd2: begin
            if (idx_r[1:0] == 2'd0) begin
              byte_cur = {3'b110, head.cp[10:6]};
            end else begin
              byte_cur = {2'b10, head.cp[5:0]};
            end
          end
          default: begin
            if (idx_r[1:0] == 2'd0) begin
              byte_cur = {4'b1110, head.cp[15:12]};
            end else if (idx_r[1:0] == 2'd1) begin
              byte_cur = {2'b10, head.cp[11:6]};
            end else begin
              byte_cur = {2'b10, head.cp[5:0]};
            end
          end
        endcase
        job_last = (idx_r[1:0] == head.code_len - 2'd1);
      end
      default: begin
        byte_cur = decl_char(idx_r);
        job_last = (idx_r == IDX_W'(DECL_LEN - 1));
      end
    endcase
  end

  assign q_pop     = adv && job_last;
  assign out_empty = !out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.out_byte    <= byte_cur;
      out_item_r.last_of_run <= job_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_START;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        if (job_last) begin
          seg_r <= SEG_START;
          idx_r <= '0;
        end else begin
          seg_r <= seg_nxt;
          idx_r <= idx_nxt;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r != SEG_START) |-> !q_empty)
    else $error("sequencer mid-job with no job queued");

  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r == SEG_FLUSH) |-> (idx_r[2:0] < head.flush_cnt))
    else $error("prefix flush index past count");

  a_decl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r == SEG_DECL) |-> (int'(idx_r) < DECL_LEN))
    else $error("declaration index past end");

endmodule

>>> src/single_byte_to_utf8_xml_recoder_top.sv
// ----------------------------------------------------------------------------
// single_byte_to_utf8_xml_recoder_top: latin-1 / windows-1252 to utf-8 recoder
// swaps a leading xml declaration for a fixed utf-8 declaration
// ----------------------------------------------------------------------------
// an accepted item's job is queued, then its bytes pass through the output register
// throughput: one output byte per cycle while a job is queued and the output
//   register is free or popped; an item causes 0 to 3 bytes (up to 7 on a broken
//   prefix, 38 for the declaration); input is taken every cycle the queue has room
// reset: synchronous, active low; clears encoding, document state, queue and output
module single_byte_to_utf8_xml_recoder_top import sbu8x_pkg::*; #(
  parameter int JobqDepth = JOBQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  // result channel
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data,
  // configuration: from_encoding
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // items are taken while the job queue has a free slot
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // front: prefix / declaration tracking and code point lookup
  sbu8x_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .job_push  (job_push),
    .job       (job_in)
  );

  // jobs waiting for the output sequencer
  sbu8x_jobq #(
    .DEPTH (JobqDepth)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job_in),
    .pop    (q_pop),
    .head   (job_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back: one utf-8 byte per cycle into the output register while a job waits and the register is free or popped
  sbu8x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (job_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

>>> tb/utf8_recode_checker.sv
// ----------------------------------------------------------------------------
// utf8_recode_checker: predicts and checks the utf-8 byte stream of the recoder
// watches the input, output and encoding ports, keeps its own document state,
// queues the bytes each accepted item should cause and compares them in order
// ----------------------------------------------------------------------------
module utf8_recode_checker import sbu8x_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        mismatch_count,
  output int        utf8_pending
);

  localparam int OPEN_LEN = 5;
  localparam int DECL_BYTES = 38;
  localparam logic [8*OPEN_LEN-1:0] OPEN_TEXT = "<?xml";
  localparam logic [8*DECL_BYTES-1:0] DECL_TEXT =
    "<?xml version=\"1.0\" encoding=\"UTF-8\"?>";

  // code points of 0x80..0x9f in windows-1252, entry 0 in the low bits
  localparam logic [32*16-1:0] WIN1252_HIGH = {
    16'h0178, 16'h017e, 16'h009d, 16'h0153, 16'h203a, 16'h0161, 16'h2122, 16'h02dc,
    16'h2014, 16'h2013, 16'h2022, 16'h201d, 16'h201c, 16'h2019, 16'h2018, 16'h0090,
    16'h008f, 16'h017d, 16'h008d, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02c6,
    16'h2021, 16'h2020, 16'h2026, 16'h201e, 16'h0192, 16'h201a, 16'h0081, 16'h20ac
  };

  typedef enum logic [1:0] {
    DOC_PREFIX,
    DOC_DECL,
    DOC_BODY
  } doc_state_t;

  doc_state_t doc_state;
  logic [2:0] prefix_hits;
  logic       after_question;
  logic       win1252;
  int         fails;

  logic [7:0] run_bytes[$];
  out_item_t  utf8_expected[$];
  out_item_t  want;

  function automatic logic [7:0] open_char(input int idx);
    return OPEN_TEXT[(OPEN_LEN - 1 - idx) * 8 +: 8];
  endfunction

  task automatic add_code_point(input logic [7:0] b);
    logic [15:0] cp;
    cp = {8'h00, b};
    if (win1252 && b[7:5] == 3'b100) begin
      cp = WIN1252_HIGH[int'(b[4:0]) * 16 +: 16];
    end
    if (cp < 16'h0080) begin
      run_bytes.push_back(cp[7:0]);
    end else if (cp < 16'h0800) begin
      run_bytes.push_back({3'b110, cp[10:6]});
      run_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      run_bytes.push_back({4'b1110, cp[15:12]});
      run_bytes.push_back({2'b10, cp[11:6]});
      run_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  task automatic flush_open();
    int k;
    for (k = 0; k < int'(prefix_hits); k++) run_bytes.push_back(open_char(k));
  endtask

  task automatic predict_utf8(input in_item_t it);
    int k;
    out_item_t entry;
    run_bytes.delete();
    case (doc_state)
      DOC_PREFIX: begin
        if (int'(prefix_hits) < OPEN_LEN && it.in_byte == open_char(int'(prefix_hits))) begin
          prefix_hits = prefix_hits + 3'd1;
          if (int'(prefix_hits) == OPEN_LEN) begin
            doc_state = DOC_DECL;
            after_question = 1'b0;
          end
        end else begin
          flush_open();
          add_code_point(it.in_byte);
          doc_state = DOC_BODY;
        end
      end
      DOC_DECL: begin
        if (after_question && it.in_byte == CHR_GT) begin
          for (k = 0; k < DECL_BYTES; k++) begin
            run_bytes.push_back(DECL_TEXT[(DECL_BYTES - 1 - k) * 8 +: 8]);
          end
          doc_state = DOC_BODY;
          after_question = 1'b0;
        end else begin
          after_question = (it.in_byte == CHR_QUEST);
        end
      end
      default: add_code_point(it.in_byte);
    endcase
    if (it.end_of_doc) begin
      // a half-matched opener is given back, an open declaration is dropped
      if (doc_state == DOC_PREFIX) flush_open();
      doc_state = DOC_PREFIX;
      prefix_hits = 3'd0;
      after_question = 1'b0;
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      entry.out_byte = run_bytes[k];
      entry.last_of_run = (k == run_bytes.size() - 1);
      utf8_expected.push_back(entry);
    end
  endtask

  task automatic note_mismatch(input string what, input out_item_t exp_item,
                               input out_item_t got_item);
    fails++;
    if (fails <= 10) begin
      $display("utf8 %s: expected byte %h last %b, got byte %h last %b", what,
               exp_item.out_byte, exp_item.last_of_run,
               got_item.out_byte, got_item.last_of_run);
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      doc_state = DOC_PREFIX;
      prefix_hits = 3'd0;
      after_question = 1'b0;
      win1252 = 1'b0;
      utf8_expected.delete();
    end else begin
      // compare first: an item taken at this edge cannot show a byte yet
      if (out_pop && !out_empty) begin
        if (utf8_expected.size() == 0) begin
          note_mismatch("byte with nothing pending", '0, out_data);
        end else begin
          want = utf8_expected.pop_front();
          if (want.out_byte !== out_data.out_byte) note_mismatch("byte", want, out_data);
          else if (want.last_of_run !== out_data.last_of_run) begin
            note_mismatch("last flag", want, out_data);
          end
        end
      end
      if (cfg_we) win1252 = cfg_wdata;
      if (in_push && !in_full) predict_utf8(in_data);
    end
    mismatch_count <= fails;
    utf8_pending <= utf8_expected.size();
  end

endmodule

>>> tb/tb_single_byte_to_utf8_xml_recoder_top.sv
// ----------------------------------------------------------------------------
// tb_single_byte_to_utf8_xml_recoder_top: stimulus and verdict for the recoder
// drives documents through the queue-style input, pops utf-8 bytes at random,
// switches the source encoding between phases and reads the checker's count
// ----------------------------------------------------------------------------
module tb_single_byte_to_utf8_xml_recoder_top;
  import sbu8x_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int READER_HOLD = 300;
  // allowance for an accepted item to pass the job queue of two and the output register
  localparam int SETTLE_CYCLES = 6;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  int mismatch_count;
  int utf8_pending;
  int cycle_count;
  int items_taken;
  int hold_cycles;
  bit gaps_on;
  bit hold_reader;

  // document under construction, sent item by item
  logic [7:0] doc_bytes[$];

  single_byte_to_utf8_xml_recoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  utf8_recode_checker recode_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .utf8_pending  (utf8_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side: pops every cycle, with random short gaps and one long hold
  initial begin
    forever begin
      if (hold_reader) begin
        // long hold so the job queue fills and in_full rises
        out_pop <= 1'b0;
        for (hold_cycles = 0; hold_cycles < READER_HOLD; hold_cycles++) @(posedge clk);
        hold_reader = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one item on the input queue; returns at the edge that takes it
  task automatic offer_item(input logic [7:0] b, input logic eod);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= {b, eod};
    do @(posedge clk); while (in_full);
    items_taken++;
  endtask

  // sends the built document, end mark on its last byte if asked
  task automatic send_doc(input logic eod_last);
    int k;
    for (k = 0; k < doc_bytes.size(); k++) begin
      offer_item(doc_bytes[k], eod_last && (k == doc_bytes.size() - 1));
    end
    doc_bytes.delete();
  endtask

  task automatic append_open(input int count);
    int k;
    for (k = 0; k < count; k++) doc_bytes.push_back(PREFIX_STR[(PREFIX_LEN - 1 - k) * 8 +: 8]);
  endtask

  // stop offering and wait until every predicted byte has come out
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (utf8_pending != 0);
    // an item with no output never enters the job queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_encoding(input logic win1252);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= win1252;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // weighted toward the windows-1252 range and the markup characters
  function automatic logic [7:0] pick_source_byte();
    logic [7:0] b;
    logic [47:0] markup;
    markup = "<?>xml";
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'h80 + 8'($urandom_range(0, 31));
      3, 4:    b = 8'($urandom_range(8'h20, 8'h7e));
      5:       b = 8'($urandom_range(8'ha0, 8'hff));
      6:       b = markup[$urandom_range(0, 5) * 8 +: 8];
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // inside a declaration: many question marks so the closer shows up often
  function automatic logic [7:0] pick_decl_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = CHR_QUEST;
      4:          b = CHR_GT;
      default:    b = pick_source_byte();
    endcase
    return b;
  endfunction

  task automatic send_document();
    int kind;
    int n;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      // well-formed declaration, then a body
      append_open(PREFIX_LEN);
      repeat ($urandom_range(0, 6)) doc_bytes.push_back(pick_decl_byte());
      doc_bytes.push_back(CHR_QUEST);
      doc_bytes.push_back(CHR_GT);
      repeat ($urandom_range(0, 8)) doc_bytes.push_back(pick_source_byte());
    end else if (kind == 4) begin
      // opener broken after a few bytes
      append_open($urandom_range(0, 4));
      repeat ($urandom_range(1, 6)) doc_bytes.push_back(pick_source_byte());
    end else if (kind == 5) begin
      // document ends inside the opener
      append_open($urandom_range(1, 4));
    end else if (kind == 6) begin
      // declaration that never closes
      append_open(PREFIX_LEN);
      repeat ($urandom_range(0, 6)) begin
        b = pick_decl_byte();
        if (b == CHR_GT) b = 8'h3d;
        doc_bytes.push_back(b);
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) doc_bytes.push_back(pick_source_byte());
    end
    // now and then no end mark, so the next document runs on from where this one left off
    send_doc($urandom_range(0, 9) != 0);
  endtask

  task automatic run_documents(input int count);
    int target;
    target = items_taken + count;
    while (items_taken < target) send_document();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    items_taken = 0;
    gaps_on = 1'b1;
    hold_reader = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, windows-1252: euro sign, unmapped slot, two-byte and
    // three-byte table entries
    write_encoding(1'b1);
    doc_bytes.push_back(8'h80);
    doc_bytes.push_back(8'h81);
    doc_bytes.push_back(8'h9f);
    doc_bytes.push_back(8'h99);
    send_doc(1'b1);
    // shortest declaration, swapped for the fixed one, then the top byte
    append_open(PREFIX_LEN);
    doc_bytes.push_back(CHR_QUEST);
    doc_bytes.push_back(CHR_GT);
    doc_bytes.push_back(8'hff);
    send_doc(1'b1);

    // directed, latin-1
    write_encoding(1'b0);
    // opener broken on its last byte: four bytes flushed, then the byte
    append_open(4);
    doc_bytes.push_back(8'h9f);
    send_doc(1'b1);
    // document ends halfway through the opener
    append_open(2);
    send_doc(1'b1);
    // document that is only the opener: nothing comes out
    append_open(PREFIX_LEN);
    send_doc(1'b1);
    doc_bytes.push_back(8'h00);
    send_doc(1'b1);

    // random documents, windows-1252
    write_encoding(1'b1);
    run_documents(60);

    // latin-1 while the output side holds off for a long stretch
    write_encoding(1'b0);
    hold_reader = 1'b1;
    run_documents(50);

    // windows-1252, with a full pause halfway through
    write_encoding(1'b1);
    run_documents(25);
    wait_drained();
    run_documents(25);

    // last stretch at full rate on both sides
    write_encoding(1'b0);
    gaps_on = 1'b0;
    run_documents(30);

    wait_drained();
    if (mismatch_count == 0 && utf8_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/sbu8x_pkg.sv
src/sbu8x_front.sv
src/sbu8x_jobq.sv
src/sbu8x_back.sv
src/single_byte_to_utf8_xml_recoder_top.sv
tb/utf8_recode_checker.sv
tb/tb_single_byte_to_utf8_xml_recoder_top.sv
